// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication checked outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/slis_pkg.sv =====
// Types, codes and constants for the slot list insert/shift unit.
package slis_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int POS_W     = 5;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_VALUE  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_POS    = 3'd2;
  localparam logic [OP_W-1:0] OP_UPD_VALUE  = 3'd3;
  localparam logic [OP_W-1:0] OP_UPD_POS    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     matched;
    logic signed [DATA_W-1:0] read_value;
  } out_item_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

// ===== sv/slis_datapath.sv =====
// Slot table cells, input holding register and result register.
module slis_datapath #(
  parameter int SLOTS = slis_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  slis_pkg::dp_cmd_t  cmd,
  input  slis_pkg::in_item_t in_item,
  output slis_pkg::out_item_t out_item
);
  import slis_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [POS_W-1:0] SLOTS_P = POS_W'(SLOTS);

  in_item_t                 req_r;
  out_item_t                res_r;
  out_item_t                res_nxt;
  logic signed [DATA_W-1:0] vals_r   [SLOTS];
  logic signed [DATA_W-1:0] vals_nxt [SLOTS];
  logic [SLOTS-1:0]         occ_r;
  logic [SLOTS-1:0]         occ_nxt;

  logic                     in_range;
  logic [IDX_W-1:0]         idx;
  logic [SLOTS-1:0]         ge_mask;
  logic [SLOTS-1:0]         free_ge;
  logic [SLOTS-1:0]         first_free;
  logic [SLOTS-1:0]         window;
  logic [SLOTS-1:0]         hit;
  logic                     any_free;

  always_comb begin
    in_range   = req_r.position < SLOTS_P;
    idx        = req_r.position[IDX_W-1:0];
    for (int i = 0; i < SLOTS; i++) begin
      ge_mask[i] = POS_W'(i) >= req_r.position;
      hit[i]     = vals_r[i] == req_r.value;
    end
    free_ge    = ~occ_r & ge_mask;
    any_free   = |free_ge;
    first_free = free_ge & (~free_ge + SLOTS'(1));
    window     = ge_mask & (first_free | (first_free - SLOTS'(1)));
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      vals_nxt[i] = vals_r[i];
    end
    occ_nxt            = occ_r;
    res_nxt.status     = STAT_OK;
    res_nxt.matched    = 1'b0;
    res_nxt.read_value = '0;
    case (req_r.op)
      OP_INSERT: begin
        if (!in_range) begin
          res_nxt.status = STAT_RANGE;
        end else if (!any_free) begin
          res_nxt.status = STAT_FULL;
        end else begin
          for (int i = 1; i < SLOTS; i++) begin
            if (window[i] && !ge_mask[i-1] == 1'b0 && POS_W'(i) != req_r.position) begin
              vals_nxt[i] = vals_r[i-1];
            end
          end
          vals_nxt[idx] = req_r.value;
          occ_nxt       = occ_r | first_free;
        end
      end
      OP_DEL_VALUE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit[i]) begin
            vals_nxt[i] = '0;
            occ_nxt[i]  = 1'b0;
          end
        end
        res_nxt.matched = |hit;
      end
      OP_DEL_POS: begin
        if (!in_range) begin
          res_nxt.status = STAT_RANGE;
        end else begin
          res_nxt.read_value = vals_r[idx];
          vals_nxt[idx]      = '0;
          occ_nxt[idx]       = 1'b0;
        end
      end
      OP_UPD_VALUE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit[i]) begin
            vals_nxt[i] = req_r.new_value;
          end
        end
      end
      OP_UPD_POS: begin
        if (!in_range) begin
          res_nxt.status = STAT_RANGE;
        end else begin
          vals_nxt[idx] = req_r.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        vals_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      occ_r <= occ_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        vals_r[i] <= vals_nxt[i];
      end
    end
  end

  assign out_item = res_r;

endmodule

// ===== sv/slis_ctrl.sv =====
// Sequencer: input accept, table execute and result handshake.
module slis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output slis_pkg::dp_cmd_t cmd
);
  import slis_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    slot_free     = !out_valid_r || out_ready;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/slot_list_insert_shift_unit.sv =====
// Top level of the slot list insert/shift unit.
//
//  channel | ports                        | beat
//  --------+------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_item  | op, position, value, new_value
//  result  | out_valid, out_ready, out_item | status, matched, read_value
//
// Each beat is first registered in the input holding register, then run on
// all slot cells in parallel (compare, shift window and write in one step).
// The next input beat is taken while the previous result waits on out_ready.
// Execution waits only while the result register still holds an untaken beat.
// Reset clears every slot value and occupied mark at once.
module slot_list_insert_shift_unit #(
  parameter int SLOTS = slis_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slis_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output slis_pkg::out_item_t out_item
);
  import slis_pkg::*;

  dp_cmd_t cmd;

  slis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  slis_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "second beat taken before execute")
  `ASSERT_CLK(a_status_code, clk, rst_n, out_valid |-> (out_item.status == STAT_OK || out_item.status == STAT_RANGE || out_item.status == STAT_FULL), "bad status code")
  `ASSERT_CLK(a_match_ok, clk, rst_n, (out_valid && out_item.matched) |-> (out_item.status == STAT_OK), "match with error status")
  `ASSERT_CLK(a_read_ok, clk, rst_n, (out_valid && out_item.read_value != '0) |-> (out_item.status == STAT_OK && !out_item.matched), "read value with error or match")
  `ASSERT_ALWAYS(a_exec_one, clk, !(cmd.load && cmd.exec), "load and execute together")

endmodule
